### design/plac_pkg.sv
// ============================================================================
// plac_pkg
// Shared widths and the sequencer state type for the polyline length block.
// ============================================================================
`default_nettype none

package plac_pkg;

    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int RAD_W     = 2 * DIFF_W;
    localparam int ROOT_W    = DIFF_W;
    localparam int ITER_W    = $clog2(ROOT_W);
    localparam int SUM_W     = 40;
    localparam int CNT_OUT_W = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUMSQ,
        ST_ROOT,
        ST_ACCUM,
        ST_RESULT
    } plac_state_t;

endpackage

`default_nettype wire

### design/plac_sqrt.sv
// ============================================================================
// plac_sqrt
// Restoring digit-recurrence integer square root, one root bit per cycle.
// ============================================================================
`default_nettype none

module plac_sqrt (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [plac_pkg::RAD_W-1:0]  radicand,
    output logic                             done,
    output logic [plac_pkg::ROOT_W-1:0]      root
);
    import plac_pkg::*;

    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W:0]     rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [ROOT_W+2:0]   rem_shift;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   rem_diff;
    logic                fits;

    assign rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign rem_diff  = rem_shift - trial;
    assign fits      = rem_shift >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && iter_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            iter_reg <= ITER_W'(ROOT_W - 1);
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            iter_reg <= iter_reg - 1'b1;
            if (fits) begin
                rem_reg  <= rem_diff[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_shift[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### design/polyline_length_accumulator.sv
// ============================================================================
// polyline_length_accumulator
// Sums Euclidean segment lengths of a stream of Q15.8 polyline vertices.
// ============================================================================
// Vertices arrive as words of {y, x}; tlast marks the final vertex. The first
// vertex of a figure runs no segment. Every later vertex keeps the sequencer
// busy after it is taken: one subtract, two squarings through one shared
// 25x25 multiplier, a sum of squares, the bit-serial square root, its done
// strobe and the accumulate. A new vertex is not taken until the last one is
// through. In closed mode the final vertex of a figure of two or more vertices
// also runs the closing segment back to the first vertex. s_axis_tready is
// high only while the sequencer is idle; a finished result sits in an output
// register until taken, and a new figure may start meanwhile.
`default_nettype none

module polyline_length_accumulator #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,     // closed_mode
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,  // [23:0] x_coord, [47:24] y_coord
    input  wire logic         s_axis_tlast,  // last_point
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [55:0]       m_axis_tdata,  // [39:0] total_length, [50:40] point_count
    output logic [0:0]        m_axis_tuser   // [0] too_few_points
);
    import plac_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    plac_state_t state_reg, state_next;

    logic                       closed_mode_reg;
    logic signed [COORD_W-1:0]  first_x_reg, first_y_reg;
    logic signed [COORD_W-1:0]  prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0]  cur_x_reg, cur_y_reg;
    logic signed [COORD_W-1:0]  opa_x_reg, opa_y_reg;
    logic                       last_reg;
    logic                       closing_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [DIFF_W-1:0]          dx_abs_reg, dy_abs_reg;
    logic [RAD_W-1:0]           prod_reg, sq_x_reg;

    logic [SUM_W-1:0]           m_total_reg;
    logic [CNT_OUT_W-1:0]       m_count_reg;
    logic                       m_flag_reg;
    logic                       m_valid_reg;

    logic                       in_acc;
    logic                       out_load;
    logic                       sqrt_start;
    logic                       sqrt_done;
    logic [ROOT_W-1:0]          sqrt_root;

    logic signed [COORD_W-1:0]  in_x, in_y;
    logic signed [DIFF_W-1:0]   dx, dy;
    logic [DIFF_W-1:0]          mul_in;
    logic [RAD_W-1:0]           prod;
    logic [SUM_W:0]             sum_ext;

    assign in_x = s_axis_tdata[23:0];
    assign in_y = s_axis_tdata[47:24];

    plac_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_x_reg + prod_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (cnt_reg != '0) begin
                        state_next = ST_DIFF;
                    end else if (s_axis_tlast) begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_DIFF:  state_next = ST_SQ_X;
            ST_SQ_X:  state_next = ST_SQ_Y;
            ST_SQ_Y:  state_next = ST_SUMSQ;
            ST_SUMSQ: state_next = ST_ROOT;
            ST_ROOT: begin
                if (sqrt_done) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                if (closing_reg || !last_reg) begin
                    state_next = closing_reg ? ST_RESULT : ST_IDLE;
                end else if (closed_mode_reg) begin
                    state_next = ST_DIFF;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        s_axis_tready = (state_reg == ST_IDLE);
        sqrt_start    = (state_reg == ST_SUMSQ);
        out_load      = (state_reg == ST_RESULT) && (!m_valid_reg || m_axis_tready);
    end

    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign dx      = DIFF_W'(opa_x_reg) - DIFF_W'(cur_x_reg);
    assign dy      = DIFF_W'(opa_y_reg) - DIFF_W'(cur_y_reg);
    assign mul_in  = (state_reg == ST_SQ_X) ? dx_abs_reg : dy_abs_reg;
    assign prod    = RAD_W'(mul_in) * RAD_W'(mul_in);
    assign sum_ext = {1'b0, sum_reg} + (SUM_W + 1)'(sqrt_root);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            closed_mode_reg <= 1'b0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                closed_mode_reg <= cfg_wdata;
            end
            if (in_acc) begin
                if (cnt_reg == '0) begin
                    cnt_reg <= CNT_W'(1);
                end else if (cnt_reg < CNT_W'(MAX_POINTS)) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end else if (out_load) begin
                cnt_reg <= '0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    cur_x_reg   <= in_x;
                    cur_y_reg   <= in_y;
                    prev_x_reg  <= in_x;
                    prev_y_reg  <= in_y;
                    opa_x_reg   <= prev_x_reg;
                    opa_y_reg   <= prev_y_reg;
                    last_reg    <= s_axis_tlast;
                    closing_reg <= 1'b0;
                    if (cnt_reg == '0) begin
                        first_x_reg <= in_x;
                        first_y_reg <= in_y;
                        sum_reg     <= '0;
                    end
                end
            end
            ST_DIFF: begin
                dx_abs_reg <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
                dy_abs_reg <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
            end
            ST_SQ_X: begin
                prod_reg <= prod;
            end
            ST_SQ_Y: begin
                sq_x_reg <= prod_reg;
                prod_reg <= prod;
            end
            ST_ACCUM: begin
                sum_reg <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
                if (!closing_reg && last_reg && closed_mode_reg) begin
                    opa_x_reg   <= first_x_reg;
                    opa_y_reg   <= first_y_reg;
                    closing_reg <= 1'b1;
                end
            end
            ST_RESULT: begin
                if (out_load) begin
                    m_total_reg <= sum_reg;
                    m_count_reg <= CNT_OUT_W'(cnt_reg);
                    m_flag_reg  <= closed_mode_reg && (cnt_reg < CNT_W'(2));
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, m_count_reg, m_total_reg};
    assign m_axis_tuser  = m_flag_reg;

endmodule

`default_nettype wire

### tb/tb_polyline_length_accumulator.sv
// ----------------------------------------------------------------------------
// tb_polyline_length_accumulator
// Streams polyline vertices into the block in open and closed mode. Each
// emitted total is checked against a local predictor of the segment sum,
// point count and short-figure flag. The run covers source idling, sink
// stalls and a long sink hold-off.
// ----------------------------------------------------------------------------
module tb_polyline_length_accumulator;
    timeunit 1ns;
    timeprecision 1ps;

    import plac_pkg::*;

    localparam int POINT_LIMIT    = 1024;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [SUM_W-1:0]          length_t;

    typedef struct packed {
        length_t              total;
        logic [CNT_OUT_W-1:0] count;
        logic                 too_few;
    } figure_total_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [23:0] x_coord, [47:24] y_coord
    logic        s_axis_tlast;   // last_point
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;   // [39:0] total_length, [50:40] point_count
    logic [0:0]  m_axis_tuser;   // [0] too_few_points

    polyline_length_accumulator #(
        .MAX_POINTS(POINT_LIMIT)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    bit      closed_mode_q = 1'b0;
    coord_t  first_x = '0;
    coord_t  first_y = '0;
    coord_t  prev_x = '0;
    coord_t  prev_y = '0;
    length_t path_sum = '0;
    int      vertex_cnt = 0;

    figure_total_t pending_totals[$];

    int source_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_off_left = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int vertices_sent = 0;
    int figures_sent = 0;
    int short_figures = 0;
    int totals_checked = 0;

    function automatic length_t seg_length(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        longint          dx;
        longint          dy;
        longint unsigned radicand;
        longint unsigned root;
        longint unsigned trial;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        radicand = dx * dx + dy * dy;
        root = 0;
        for (int b = 25; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        return root[SUM_W-1:0];
    endfunction

    function automatic length_t sat_add(length_t a, length_t b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic void track_vertex(coord_t x, coord_t y, bit last);
        figure_total_t res;
        bit            short_fig;
        if (vertex_cnt == 0) begin
            first_x = x;
            first_y = y;
            path_sum = '0;
            vertex_cnt = 1;
        end else begin
            path_sum = sat_add(path_sum, seg_length(prev_x, prev_y, x, y));
            if (vertex_cnt < POINT_LIMIT) begin
                vertex_cnt++;
            end
        end
        prev_x = x;
        prev_y = y;
        if (!last) begin
            return;
        end
        short_fig = closed_mode_q && (vertex_cnt < 2);
        if (closed_mode_q && !short_fig) begin
            path_sum = sat_add(path_sum, seg_length(x, y, first_x, first_y));
        end
        res.total = short_fig ? '0 : path_sum;
        res.count = vertex_cnt[CNT_OUT_W-1:0];
        res.too_few = short_fig;
        pending_totals = {pending_totals, res};
        path_sum = '0;
        vertex_cnt = 0;
        figures_sent++;
        if (short_fig) begin
            short_figures++;
        end
    endfunction

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    function automatic void check_total();
        figure_total_t        want;
        length_t              got_total;
        logic [CNT_OUT_W-1:0] got_count;
        logic                 got_flag;
        got_total = m_axis_tdata[SUM_W-1:0];
        got_count = m_axis_tdata[SUM_W +: CNT_OUT_W];
        got_flag = m_axis_tuser[0];
        if (pending_totals.size() == 0) begin
            flag_error($sformatf("unexpected word total=%0d count=%0d flag=%0b",
                                 got_total, got_count, got_flag));
            return;
        end
        want = pending_totals.pop_front();
        totals_checked++;
        if (got_total !== want.total) begin
            flag_error($sformatf("total_length exp %0d got %0d", want.total, got_total));
        end
        if (got_count !== want.count) begin
            flag_error($sformatf("point_count exp %0d got %0d", want.count, got_count));
        end
        if (got_flag !== want.too_few) begin
            flag_error($sformatf("too_few_points exp %0b got %0b", want.too_few, got_flag));
        end
    endfunction

    // sink side: check accepted words, then decide tready for the next edge
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            check_total();
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_vertex(input coord_t x, input coord_t y, input bit last);
        while ($urandom_range(99) < source_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y, x};
        s_axis_tlast <= last;
        do @(posedge aclk); while (!s_axis_tready);
        track_vertex(x, y, last);
        vertices_sent++;
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_totals.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_closed_mode(input bit mode);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we <= 1'b0;
        closed_mode_q = mode;
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(5))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return coord_t'(int'($urandom_range(2047)) - 1024);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_random_figures(input int n_vertices);
        int sent;
        int len;
        sent = 0;
        while (sent < n_vertices) begin
            case ($urandom_range(19))
                0, 1, 2: len = 1;
                3, 4, 5: len = $urandom_range(7, 20);
                default: len = $urandom_range(2, 6);
            endcase
            for (int i = 0; i < len; i++) begin
                send_vertex(pick_coord(), pick_coord(), i == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic test_open_directed();
        set_closed_mode(1'b0);
        send_vertex(24'sd0, 24'sd0, 1'b1);
        send_vertex(24'sh800000, 24'sh800000, 1'b0);
        send_vertex(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        send_vertex(24'sh7FFFFF, 24'sh800000, 1'b0);
        send_vertex(24'sh800000, 24'sh7FFFFF, 1'b0);
        send_vertex(24'sd0, 24'sd0, 1'b0);
        send_vertex(24'sd0, 24'sd0, 1'b1);
        send_vertex(24'sd768, 24'sd0, 1'b0);
        send_vertex(24'sd0, 24'sd1024, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_closed_directed();
        set_closed_mode(1'b1);
        send_vertex(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        send_vertex(24'sh800000, 24'sh7FFFFF, 1'b0);
        send_vertex(24'sh7FFFFF, 24'sh800000, 1'b1);
        send_vertex(24'sd0, 24'sd0, 1'b0);
        send_vertex(24'sd768, 24'sd0, 1'b0);
        send_vertex(24'sd768, 24'sd1024, 1'b1);
        send_vertex(24'sd100, -24'sd100, 1'b1);
        send_vertex(-24'sd1, -24'sd1, 1'b0);
        send_vertex(24'sd1, 24'sd1, 1'b1);
        wait_for_drain();
    endtask

    // sink holds off while the source keeps offering, so the block backs up
    task automatic test_sink_hold_off();
        set_closed_mode(1'b1);
        hold_off_left = 600;
        for (int i = 0; i < 32; i++) begin
            send_vertex(pick_coord(), pick_coord(), i % 2 == 1);
        end
        wait_for_drain();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input bit mode);
        set_closed_mode(mode);
        source_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        send_random_figures(120);
        wait_for_drain();
        source_idle_pct = 0;
        sink_stall_pct = 0;
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_open_directed();
        test_closed_directed();
        test_sink_hold_off();
        test_random_phase(0, 0, 1'b0);
        test_random_phase(79, 0, 1'b1);
        test_random_phase(0, 79, 1'b0);
        test_random_phase(38, 38, 1'b1);

        $display("Sent %0d vertices in %0d figures (%0d short closed), checked %0d totals.",
                 vertices_sent, figures_sent, short_figures, totals_checked);
        $display("Open/closed modes, single-vertex and full-scale figures, idle/stall mixes, hold-off.");
        if (error_count == 0 && pending_totals.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d totals outstanding", error_count,
                     pending_totals.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
design/plac_pkg.sv
design/plac_sqrt.sv
design/polyline_length_accumulator.sv
tb/tb_polyline_length_accumulator.sv
